@@ rtl/range_toggle_count_tree_core_defines.svh @@
// Assertion macros used by the range toggle and count tree controller.
`ifndef RANGE_TOGGLE_COUNT_TREE_CORE_DEFINES_SVH
`define RANGE_TOGGLE_COUNT_TREE_CORE_DEFINES_SVH

// Immediate implication checked at every clock edge outside reset.
`define RTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rtc_pkg.sv @@
// Shared constants and types for the range toggle and count tree.
`timescale 1ns / 1ps

package rtc_pkg;

    localparam int MAX_SWITCHES = 1024;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;
    localparam int NODE_DEPTH   = 4 * MAX_SWITCHES;
    localparam int NODE_AW      = 12;
    localparam int STK_DEPTH    = 11;
    localparam int SP_W         = 4;

    localparam logic CMD_TOGGLE = 1'b0;
    localparam logic CMD_COUNT  = 1'b1;

    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] waddr;
        logic [CNT_W-1:0]   wdata;
        logic [NODE_AW-1:0] raddr;
    } cnt_port_t;

    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] waddr;
        logic               wdata;
        logic [NODE_AW-1:0] raddr;
    } flip_port_t;

    typedef struct packed {
        logic             start;
        logic             cmd;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [CNT_W-1:0] n;
        logic             res_free;
    } ctrl_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             is_count;
        logic [CNT_W-1:0] result;
    } ctrl_stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ENTER_RD,
        ST_ENTER_EV,
        ST_PF_L,
        ST_PF_R,
        ST_PF_W,
        ST_DECIDE,
        ST_POP,
        ST_RESUME,
        ST_C_RD0,
        ST_C_RD1,
        ST_C_WR,
        ST_DONE
    } state_t;

endpackage

@@ rtl/rtc_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module rtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/rtc_ctrl.sv @@
// Tree walk sequencer: explicit frame stack, node read-modify-write and lazy flips.
`timescale 1ns / 1ps
`include "range_toggle_count_tree_core_defines.svh"

module rtc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rtc_pkg::ctrl_req_t            req,
    output rtc_pkg::ctrl_stat_t           stat,
    output rtc_pkg::cnt_port_t            cnt_port,
    input  logic [rtc_pkg::CNT_W-1:0]     cnt_rdata,
    output rtc_pkg::flip_port_t           flip_port,
    input  logic                          flip_rdata
);

    localparam logic [1:0] PH_ENTER = 2'd0;
    localparam logic [1:0] PH_LEFT  = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;

    rtc_pkg::state_t state_reg, state_next;

    logic [rtc_pkg::NODE_AW-1:0] k_stk  [0:rtc_pkg::STK_DEPTH-1];
    logic [rtc_pkg::IDX_W-1:0]   s_stk  [0:rtc_pkg::STK_DEPTH-1];
    logic [rtc_pkg::IDX_W-1:0]   e_stk  [0:rtc_pkg::STK_DEPTH-1];
    logic [1:0]                  ph_stk [0:rtc_pkg::STK_DEPTH-1];
    logic [rtc_pkg::SP_W-1:0]    sp_reg;

    logic                        cmd_reg;
    logic [rtc_pkg::IDX_W-1:0]   lo_reg, hi_reg;
    logic [rtc_pkg::CNT_W-1:0]   acc_reg, cur_cnt_reg, tmp_reg;
    logic                        full_reg, disj_reg;
    logic [rtc_pkg::NODE_AW-1:0] clr_reg;

    logic [rtc_pkg::NODE_AW-1:0] cur_k, left_k, right_k;
    logic [rtc_pkg::IDX_W-1:0]   cur_s, cur_e, mid;
    logic [1:0]                  cur_ph;
    logic [rtc_pkg::CNT_W-1:0]   len, settled;
    logic                        full, disj, eff_flip, leaf;
    logic [rtc_pkg::IDX_W:0]     mid_sum;

    always_comb
    begin
        cur_k    = k_stk[sp_reg];
        cur_s    = s_stk[sp_reg];
        cur_e    = e_stk[sp_reg];
        cur_ph   = ph_stk[sp_reg];
        left_k   = {cur_k[rtc_pkg::NODE_AW-2:0], 1'b0};
        right_k  = {cur_k[rtc_pkg::NODE_AW-2:0], 1'b1};
        mid_sum  = {1'b0, cur_s} + {1'b0, cur_e};
        mid      = mid_sum[rtc_pkg::IDX_W:1];
        len      = {1'b0, cur_e} - {1'b0, cur_s} + rtc_pkg::CNT_W'(1);
        leaf     = (cur_s == cur_e);
        disj     = (lo_reg > cur_e) || (hi_reg < cur_s);
        full     = (lo_reg <= cur_s) && (cur_e <= hi_reg);
        // A pending flip and a covering toggle cancel; only their parity matters.
        eff_flip = flip_rdata ^ ((cmd_reg == rtc_pkg::CMD_TOGGLE) && full);
        settled  = eff_flip ? (len - cnt_rdata) : cnt_rdata;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtc_pkg::ST_CLEAR:
            begin
                if (&clr_reg)
                begin
                    state_next = rtc_pkg::ST_IDLE;
                end
            end
            rtc_pkg::ST_IDLE:
            begin
                if (req.start)
                begin
                    state_next = rtc_pkg::ST_ENTER_RD;
                end
            end
            rtc_pkg::ST_ENTER_RD: state_next = rtc_pkg::ST_ENTER_EV;
            rtc_pkg::ST_ENTER_EV:
            begin
                if (eff_flip && !leaf)
                begin
                    state_next = rtc_pkg::ST_PF_L;
                end
                else
                begin
                    state_next = rtc_pkg::ST_DECIDE;
                end
            end
            rtc_pkg::ST_PF_L: state_next = rtc_pkg::ST_PF_R;
            rtc_pkg::ST_PF_R: state_next = rtc_pkg::ST_PF_W;
            rtc_pkg::ST_PF_W: state_next = rtc_pkg::ST_DECIDE;
            rtc_pkg::ST_DECIDE:
            begin
                if (disj_reg || full_reg)
                begin
                    state_next = rtc_pkg::ST_POP;
                end
                else
                begin
                    state_next = rtc_pkg::ST_ENTER_RD;
                end
            end
            rtc_pkg::ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = rtc_pkg::ST_DONE;
                end
                else
                begin
                    state_next = rtc_pkg::ST_RESUME;
                end
            end
            rtc_pkg::ST_RESUME:
            begin
                if (cur_ph == PH_LEFT)
                begin
                    state_next = rtc_pkg::ST_ENTER_RD;
                end
                else if (cmd_reg == rtc_pkg::CMD_TOGGLE)
                begin
                    state_next = rtc_pkg::ST_C_RD0;
                end
                else
                begin
                    state_next = rtc_pkg::ST_POP;
                end
            end
            rtc_pkg::ST_C_RD0: state_next = rtc_pkg::ST_C_RD1;
            rtc_pkg::ST_C_RD1: state_next = rtc_pkg::ST_C_WR;
            rtc_pkg::ST_C_WR:  state_next = rtc_pkg::ST_POP;
            rtc_pkg::ST_DONE:
            begin
                if ((cmd_reg == rtc_pkg::CMD_TOGGLE) || req.res_free)
                begin
                    state_next = rtc_pkg::ST_IDLE;
                end
            end
            default: state_next = rtc_pkg::ST_CLEAR;
        endcase
    end

    // Memory ports and status.
    always_comb
    begin
        cnt_port  = '0;
        flip_port = '0;
        case (state_reg)
            rtc_pkg::ST_CLEAR:
            begin
                cnt_port.we   = 1'b1;
                cnt_port.waddr = clr_reg;
                flip_port.we  = 1'b1;
                flip_port.waddr = clr_reg;
            end
            rtc_pkg::ST_ENTER_RD:
            begin
                cnt_port.raddr  = cur_k;
                flip_port.raddr = cur_k;
            end
            rtc_pkg::ST_ENTER_EV:
            begin
                cnt_port.we     = flip_rdata | eff_flip;
                cnt_port.waddr  = cur_k;
                cnt_port.wdata  = settled;
                flip_port.we    = flip_rdata;
                flip_port.waddr = cur_k;
            end
            rtc_pkg::ST_PF_L:
            begin
                flip_port.raddr = left_k;
            end
            rtc_pkg::ST_PF_R:
            begin
                flip_port.we    = 1'b1;
                flip_port.waddr = left_k;
                flip_port.wdata = ~flip_rdata;
                flip_port.raddr = right_k;
            end
            rtc_pkg::ST_PF_W:
            begin
                flip_port.we    = 1'b1;
                flip_port.waddr = right_k;
                flip_port.wdata = ~flip_rdata;
            end
            rtc_pkg::ST_C_RD0:
            begin
                cnt_port.raddr = left_k;
            end
            rtc_pkg::ST_C_RD1:
            begin
                cnt_port.raddr = right_k;
            end
            rtc_pkg::ST_C_WR:
            begin
                cnt_port.we    = 1'b1;
                cnt_port.waddr = cur_k;
                cnt_port.wdata = tmp_reg + cnt_rdata;
            end
            default:
            begin
                cnt_port  = '0;
                flip_port = '0;
            end
        endcase
        stat.busy     = (state_reg != rtc_pkg::ST_IDLE);
        stat.done     = (state_reg == rtc_pkg::ST_DONE) &&
                        ((cmd_reg == rtc_pkg::CMD_TOGGLE) || req.res_free);
        stat.is_count = (cmd_reg == rtc_pkg::CMD_COUNT);
        stat.result   = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtc_pkg::ST_CLEAR;
            sp_reg    <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                rtc_pkg::ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                rtc_pkg::ST_IDLE:
                begin
                    if (req.start)
                    begin
                        sp_reg <= '0;
                    end
                end
                rtc_pkg::ST_DECIDE:
                begin
                    if (!(disj_reg || full_reg))
                    begin
                        sp_reg <= sp_reg + 1'b1;
                    end
                end
                rtc_pkg::ST_POP:
                begin
                    if (sp_reg != '0)
                    begin
                        sp_reg <= sp_reg - 1'b1;
                    end
                end
                rtc_pkg::ST_RESUME:
                begin
                    if (cur_ph == PH_LEFT)
                    begin
                        sp_reg <= sp_reg + 1'b1;
                    end
                end
                default:
                begin
                    sp_reg <= sp_reg;
                end
            endcase
        end
    end

    // Frame stack and datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rtc_pkg::ST_IDLE:
            begin
                if (req.start)
                begin
                    cmd_reg   <= req.cmd;
                    lo_reg    <= req.lo;
                    hi_reg    <= req.hi;
                    acc_reg   <= '0;
                    k_stk[0]  <= rtc_pkg::NODE_AW'(1);
                    s_stk[0]  <= '0;
                    e_stk[0]  <= rtc_pkg::IDX_W'(req.n - rtc_pkg::CNT_W'(1));
                    ph_stk[0] <= PH_ENTER;
                end
            end
            rtc_pkg::ST_ENTER_EV:
            begin
                cur_cnt_reg <= settled;
                full_reg    <= full;
                disj_reg    <= disj;
            end
            rtc_pkg::ST_DECIDE:
            begin
                if (disj_reg || full_reg)
                begin
                    if ((cmd_reg == rtc_pkg::CMD_COUNT) && full_reg)
                    begin
                        acc_reg <= acc_reg + cur_cnt_reg;
                    end
                end
                else
                begin
                    ph_stk[sp_reg]      <= PH_LEFT;
                    k_stk[sp_reg + 1'b1]  <= left_k;
                    s_stk[sp_reg + 1'b1]  <= cur_s;
                    e_stk[sp_reg + 1'b1]  <= mid;
                    ph_stk[sp_reg + 1'b1] <= PH_ENTER;
                end
            end
            rtc_pkg::ST_RESUME:
            begin
                if (cur_ph == PH_LEFT)
                begin
                    ph_stk[sp_reg]      <= PH_RIGHT;
                    k_stk[sp_reg + 1'b1]  <= right_k;
                    s_stk[sp_reg + 1'b1]  <= mid + 1'b1;
                    e_stk[sp_reg + 1'b1]  <= cur_e;
                    ph_stk[sp_reg + 1'b1] <= PH_ENTER;
                end
            end
            rtc_pkg::ST_C_RD1: tmp_reg <= cnt_rdata;
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

    `RTC_ASSERT_NOW(a_sp_bound, 1'b1, sp_reg < rtc_pkg::SP_W'(rtc_pkg::STK_DEPTH), "stack overflow")
    `RTC_ASSERT_NOW(a_start_idle, req.start, state_reg == rtc_pkg::ST_IDLE, "start while busy")
    `RTC_ASSERT_NEXT(a_push_done, state_reg == rtc_pkg::ST_PF_W, state_reg == rtc_pkg::ST_DECIDE, "flip push path broken")
    `RTC_ASSERT_NEXT(a_done_idle, stat.done, state_reg == rtc_pkg::ST_IDLE, "done without return to idle")

endmodule

@@ rtl/range_toggle_count_tree_core.sv @@
// Top level of the range toggle and count tree: channels, config register, result register.
`timescale 1ns / 1ps
// Usage:
// A request on the cmd channel (cmd_valid, cmd_stall) carries cmd, range_low and
// range_high. cmd 0 inverts every switch in the inclusive range and gives no result;
// cmd 1 gives one result on the res channel (res_valid, res_stall): on_count.
// An empty or inverted range is finished at once; a count request on it returns zero.
// switch_count is written through cfg_valid/cfg_ready/cfg_data while the block is idle;
// zero is taken as one and values above 1024 saturate.
// Each request walks the tree in a node memory and a flip memory, both with a
// registered read. A node where the walk stops goes through read, settle, optional
// flip push to the children, decide and pop; a node that is split is also resumed
// after each child, and a toggle recombines the children on the way up. One request
// is in work at a time.
// After reset a clearing pass zeroes all 4096 entries of both memories; cmd_stall stays
// high during it. A finished count waits in the result register while res_stall is
// high, and cmd_stall stays high until that result is taken.

module range_toggle_count_tree_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic                         cmd,
    input  logic [rtc_pkg::IDX_W-1:0]    range_low,
    input  logic [rtc_pkg::IDX_W-1:0]    range_high,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [rtc_pkg::CNT_W-1:0]    on_count,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rtc_pkg::CNT_W-1:0]    cfg_data
);

    rtc_pkg::ctrl_req_t  req;
    rtc_pkg::ctrl_stat_t stat;
    rtc_pkg::cnt_port_t  cnt_port;
    rtc_pkg::flip_port_t flip_port;
    logic [rtc_pkg::CNT_W-1:0] cnt_rdata;
    logic                      flip_rdata;

    logic [rtc_pkg::CNT_W-1:0] n_reg;
    logic                      res_valid_reg;
    logic [rtc_pkg::CNT_W-1:0] on_count_reg;
    logic                      accept, res_free, empty_range;

    assign res_free    = !res_valid_reg || !res_stall;
    assign cmd_stall   = stat.busy || (res_valid_reg && res_stall);
    assign accept      = cmd_valid && !cmd_stall;
    assign empty_range = (range_low > range_high);
    assign cfg_ready   = !stat.busy;
    assign res_valid   = res_valid_reg;
    assign on_count    = on_count_reg;

    always_comb
    begin
        req.start    = accept && !empty_range;
        req.cmd      = cmd;
        req.lo       = range_low;
        req.hi       = range_high;
        req.n        = n_reg;
        req.res_free = res_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= rtc_pkg::CNT_W'(rtc_pkg::MAX_SWITCHES);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data == '0)
                begin
                    n_reg <= rtc_pkg::CNT_W'(1);
                end
                else if (cfg_data > rtc_pkg::CNT_W'(rtc_pkg::MAX_SWITCHES))
                begin
                    n_reg <= rtc_pkg::CNT_W'(rtc_pkg::MAX_SWITCHES);
                end
                else
                begin
                    n_reg <= cfg_data;
                end
            end
            if (accept && empty_range && (cmd == rtc_pkg::CMD_COUNT))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (stat.done && stat.is_count)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && empty_range && (cmd == rtc_pkg::CMD_COUNT))
        begin
            on_count_reg <= '0;
        end
        else if (stat.done && stat.is_count)
        begin
            on_count_reg <= stat.result;
        end
    end

    rtc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .stat       (stat),
        .cnt_port   (cnt_port),
        .cnt_rdata  (cnt_rdata),
        .flip_port  (flip_port),
        .flip_rdata (flip_rdata)
    );

    rtc_ram #(
        .WIDTH (rtc_pkg::CNT_W),
        .DEPTH (rtc_pkg::NODE_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_port.we),
        .waddr (cnt_port.waddr),
        .wdata (cnt_port.wdata),
        .raddr (cnt_port.raddr),
        .rdata (cnt_rdata)
    );

    rtc_ram #(
        .WIDTH (1),
        .DEPTH (rtc_pkg::NODE_DEPTH)
    ) u_flip_ram (
        .clk   (clk),
        .we    (flip_port.we),
        .waddr (flip_port.waddr),
        .wdata (flip_port.wdata),
        .raddr (flip_port.raddr),
        .rdata (flip_rdata)
    );

endmodule
